### rtl/screen_edge_zone_color_averager_top_defines.svh
// Assertion macros for the edge zone color averager.
// Both macros sample on i_clk; the first ignores cycles in reset.
`ifndef SCREEN_EDGE_ZONE_COLOR_AVERAGER_TOP_DEFINES_SVH
`define SCREEN_EDGE_ZONE_COLOR_AVERAGER_TOP_DEFINES_SVH

`define SEZCA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`define SEZCA_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/sezca_pkg.sv
// ----------------------------------------------------------------------------
// sezca_pkg
// Types, zone geometry and command codes shared by the edge zone averager.
// ----------------------------------------------------------------------------
package sezca_pkg;

    typedef logic [10:0] t_coord;

    typedef struct packed {
        logic       kind;
        logic [10:0] pixel_x;
        logic [10:0] pixel_y;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [6:0] led_index;
    } t_in;

    typedef struct packed {
        logic [13:0] red_out;
        logic [13:0] green_out;
        logic [13:0] blue_out;
        logic        frame_done;
    } t_out;

    localparam int LED_TOTAL   = 91;
    localparam int ADDR_W      = 7;
    localparam int OUT_W       = 14;
    localparam int QUEUE_DEPTH = 2;

    // kind codes
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // command codes passed from front to back
    typedef logic [1:0] t_op;
    localparam t_op OP_ZERO  = 2'd0;  // result of zeros, no memory access
    localparam t_op OP_ADD   = 2'd1;  // accumulate pixel into a zone
    localparam t_op OP_READ  = 2'd2;  // return one zone
    localparam t_op OP_FRAME = 2'd3;  // scale every zone by 1/32

    typedef struct packed {
        t_op              op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } t_cmd;

    // sample line geometry, bounds inclusive
    localparam t_coord LEFT_X    = 11'd10;
    localparam t_coord TOP_Y     = 11'd10;
    localparam t_coord RIGHT_X   = 11'd1900;
    localparam t_coord BOTTOM_Y  = 11'd1070;
    localparam t_coord FRAME_X   = 11'd1900;
    localparam t_coord FRAME_Y   = 11'd1070;
    localparam t_coord HORZ_LO   = 11'd32;
    localparam t_coord HORZ_HI   = 11'd1855;

    localparam int ZONE_SPAN   = 32;
    localparam int LEFT_ZONES  = 17;
    localparam int LEFT_LO0    = 1020;
    localparam int LEFT_STEP   = 60;
    localparam int RIGHT_ZONES = 16;
    localparam int RIGHT_LO0   = 60;
    localparam int RIGHT_STEP  = 62;

    localparam int LEFT_BASE   = 0;
    localparam int TOP_BASE    = 17;
    localparam int RIGHT_BASE  = 46;
    localparam int BOTTOM_BASE = 62;

endpackage

### rtl/sezca_front.sv
// ----------------------------------------------------------------------------
// sezca_front
// Accepts input beats and turns each into a command: zone hit, read, frame
// end or nothing to do.
// ----------------------------------------------------------------------------
module sezca_front
    import sezca_pkg::*;
(
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    input  logic i_q_full,
    output logic o_push,
    output t_cmd o_cmd
);

    logic              hit;
    logic [ADDR_W-1:0] zone;
    t_coord            top_off;
    t_coord            bot_off;
    logic              horz_in;

    assign top_off = i_in_data.pixel_x - HORZ_LO;
    assign bot_off = HORZ_HI - i_in_data.pixel_x;
    assign horz_in = (i_in_data.pixel_x >= HORZ_LO) && (i_in_data.pixel_x <= HORZ_HI);

    always_comb begin
        hit  = 1'b0;
        zone = '0;
        if (i_in_data.pixel_x == LEFT_X) begin
            for (int i = 0; i < LEFT_ZONES; i++) begin
                if (i_in_data.pixel_y >= 11'(LEFT_LO0 - LEFT_STEP * i) &&
                    i_in_data.pixel_y <= 11'(LEFT_LO0 - LEFT_STEP * i + ZONE_SPAN - 1)) begin
                    hit  = 1'b1;
                    zone = ADDR_W'(LEFT_BASE + i);
                end
            end
        end
        if (i_in_data.pixel_x == RIGHT_X) begin
            for (int i = 0; i < RIGHT_ZONES; i++) begin
                if (i_in_data.pixel_y >= 11'(RIGHT_LO0 + RIGHT_STEP * i) &&
                    i_in_data.pixel_y <= 11'(RIGHT_LO0 + RIGHT_STEP * i + ZONE_SPAN - 1)) begin
                    hit  = 1'b1;
                    zone = ADDR_W'(RIGHT_BASE + i);
                end
            end
        end
        // top and bottom zones sit on a 64-pixel grid: upper offset bits pick the zone
        if (i_in_data.pixel_y == TOP_Y && horz_in && !top_off[5]) begin
            hit  = 1'b1;
            zone = ADDR_W'(TOP_BASE) + {2'b00, top_off[10:6]};
        end
        if (i_in_data.pixel_y == BOTTOM_Y && horz_in && !bot_off[5]) begin
            hit  = 1'b1;
            zone = ADDR_W'(BOTTOM_BASE) + {2'b00, bot_off[10:6]};
        end
    end

    always_comb begin
        o_cmd.red   = i_in_data.red_in;
        o_cmd.green = i_in_data.green_in;
        o_cmd.blue  = i_in_data.blue_in;
        o_cmd.addr  = zone;
        o_cmd.op    = OP_ZERO;
        if (i_in_data.kind == KIND_READ) begin
            o_cmd.addr = i_in_data.led_index;
            if (i_in_data.led_index < ADDR_W'(LED_TOTAL)) begin
                o_cmd.op = OP_READ;
            end
        end else if (i_in_data.pixel_x == FRAME_X && i_in_data.pixel_y == FRAME_Y) begin
            o_cmd.op = OP_FRAME;
        end else if (hit) begin
            o_cmd.op = OP_ADD;
        end
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

### rtl/sezca_fifo.sv
// ----------------------------------------------------------------------------
// sezca_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module sezca_fifo
    import sezca_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/sezca_back.sv
// ----------------------------------------------------------------------------
// sezca_back
// Zone accumulator memory with read-modify-write, frame-end scaling sweep
// and the output register.
// ----------------------------------------------------------------------------
module sezca_back
    import sezca_pkg::*;
#(
    parameter int CHANNEL_ACC_WIDTH = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_cmd i_head,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int W      = CHANNEL_ACC_WIDTH;
    localparam int DATA_W = 3 * W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ACC   = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [DATA_W-1:0] r_mem [LED_TOTAL];
    logic [DATA_W-1:0] r_rd_data;
    logic [LED_TOTAL-1:0] r_vld;
    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    t_cmd              r_cmd, n_cmd;
    logic              r_out_vld;
    t_out              r_out_data;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [DATA_W-1:0] wr_data;
    logic              produce;
    t_out              prod_data;
    logic              slot_free;
    logic [DATA_W-1:0] cur;
    logic [W-1:0]      cur_r, cur_g, cur_b;

    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [7:0] b);
        logic [W:0] s;
        s = {1'b0, a} + (W + 1)'(b);
        return s[W] ? {W{1'b1}} : s[W-1:0];
    endfunction

    assign slot_free = !r_out_vld || i_out_ready;
    // entries never written since reset read as zero
    assign cur   = r_vld[r_addr] ? r_rd_data : '0;
    assign cur_r = cur[DATA_W-1:2*W];
    assign cur_g = cur[2*W-1:W];
    assign cur_b = cur[W-1:0];

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_cmd     = r_cmd;
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_addr;
        wr_en     = 1'b0;
        wr_data   = '0;
        produce   = 1'b0;
        prod_data = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_head.op)
                        OP_ZERO: begin
                            if (slot_free) begin
                                o_pop   = 1'b1;
                                produce = 1'b1;
                            end
                        end
                        OP_ADD, OP_READ: begin
                            o_pop   = 1'b1;
                            rd_en   = 1'b1;
                            rd_addr = i_head.addr;
                            n_addr  = i_head.addr;
                            n_cmd   = i_head;
                            n_state = S_ACC;
                        end
                        OP_FRAME: begin
                            o_pop   = 1'b1;
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_addr  = '0;
                            n_state = S_SWEEP;
                        end
                    endcase
                end
            end
            S_ACC: begin
                if (slot_free) begin
                    produce = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd.op == OP_ADD) begin
                        wr_en   = 1'b1;
                        wr_data = {sat_add(cur_r, r_cmd.red), sat_add(cur_g, r_cmd.green),
                                   sat_add(cur_b, r_cmd.blue)};
                    end else begin
                        prod_data.red_out   = cur_r[OUT_W-1:0];
                        prod_data.green_out = cur_g[OUT_W-1:0];
                        prod_data.blue_out  = cur_b[OUT_W-1:0];
                    end
                end
            end
            S_SWEEP: begin
                // write back entry r_addr while reading the next one
                wr_en   = 1'b1;
                wr_data = {cur_r >> 5, cur_g >> 5, cur_b >> 5};
                if (r_addr == ADDR_W'(LED_TOTAL - 1)) begin
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr + 1'b1;
                    n_addr  = r_addr + 1'b1;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    produce              = 1'b1;
                    prod_data.frame_done = 1'b1;
                    n_state              = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_cmd  <= n_cmd;
        if (produce) begin
            r_out_data <= prod_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_vld[r_addr] <= 1'b1;
            end
            if (produce) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

### rtl/screen_edge_zone_color_averager_top.sv
// A zone pixel or a read is handled as a memory read, then a write back or
// an output; a pixel off all sample lines gives its zero result directly, and
// the frame-end pixel sweeps all 91 zones, one per cycle, then gives a frame
// done beat. The queue takes new beats while it is not full.
// Reset: synchronous; zone valid bits clear at once, so all zones read zero,
// with no clearing pass.
// ----------------------------------------------------------------------------
// screen_edge_zone_color_averager_top
// Ambient lighting edge zone averager: front classifies beats, a short queue
// decouples it from the back, which owns the accumulators.
// ----------------------------------------------------------------------------
module screen_edge_zone_color_averager_top
    import sezca_pkg::*;
#(
    parameter int CHANNEL_ACC_WIDTH = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_cmd push_cmd;
    t_cmd head;

    sezca_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    sezca_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    sezca_back #(
        .CHANNEL_ACC_WIDTH (CHANNEL_ACC_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/sezca_checker.sv
// ----------------------------------------------------------------------------
// sezca_checker
// Port-level checks on the edge zone averager, bound to the top level.
// ----------------------------------------------------------------------------
`include "screen_edge_zone_color_averager_top_defines.svh"

module sezca_checker
    import sezca_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    `SEZCA_ASSERT_RST(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "output beat dropped")
    `SEZCA_ASSERT_RST(a_out_stable, o_out_valid && !i_out_ready |=> $stable(o_out_data), "stalled output beat changed")
    `SEZCA_ASSERT_ANY(a_rst_idle, !i_rst_n |=> !o_out_valid, "output valid right after reset")
    `SEZCA_ASSERT_RST(a_frame_zero, o_out_valid && o_out_data.frame_done |-> o_out_data.red_out == '0 && o_out_data.green_out == '0 && o_out_data.blue_out == '0, "frame end beat carries color")

endmodule

bind screen_edge_zone_color_averager_top sezca_checker u_checker (.*);

### tb/zone_color_checker.sv
// ----------------------------------------------------------------------------
// zone_color_checker
// Watches both channels of the edge zone averager. It keeps its own copy of
// the zone accumulators and works out the result of every accepted input
// beat. It then compares each result beat with the oldest outstanding
// prediction, field by field, and counts the mismatches.
// ----------------------------------------------------------------------------
module zone_color_checker
    import sezca_pkg::*;
#(
    parameter int ACC_W = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HORZ_ZONES   = 29;
    localparam int HORZ_STEP    = 64;
    localparam int TOP_LO0      = int'(HORZ_LO);
    localparam int BOTTOM_LO0   = int'(HORZ_HI) - ZONE_SPAN + 1;
    localparam int FRAME_SHIFT  = 5;
    localparam int REPORT_LIMIT = 10;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    logic [ACC_W-1:0] zone_red   [LED_TOTAL];
    logic [ACC_W-1:0] zone_green [LED_TOTAL];
    logic [ACC_W-1:0] zone_blue  [LED_TOTAL];

    t_out outstanding_results[$];
    int   mismatches;

    function automatic logic [ACC_W-1:0] saturating_sum(logic [ACC_W-1:0] acc,
                                                        logic [7:0] level);
        logic [ACC_W:0] total;
        total = {1'b0, acc} + (ACC_W + 1)'(level);
        return total[ACC_W] ? ACC_MAX : total[ACC_W-1:0];
    endfunction

    function automatic void add_to_zone(int zone, t_in beat);
        zone_red[zone]   = saturating_sum(zone_red[zone], beat.red_in);
        zone_green[zone] = saturating_sum(zone_green[zone], beat.green_in);
        zone_blue[zone]  = saturating_sum(zone_blue[zone], beat.blue_in);
    endfunction

    function automatic bit in_window(int coord, int lo);
        return coord >= lo && coord <= lo + ZONE_SPAN - 1;
    endfunction

    // Apply one beat to the accumulator copy and return its result.
    function automatic t_out predict_zone_result(t_in beat);
        t_out res;
        int   px;
        int   py;
        res = '0;
        px  = int'(beat.pixel_x);
        py  = int'(beat.pixel_y);
        if (beat.kind == KIND_READ) begin
            if (int'(beat.led_index) < LED_TOTAL) begin
                res.red_out   = zone_red[beat.led_index][OUT_W-1:0];
                res.green_out = zone_green[beat.led_index][OUT_W-1:0];
                res.blue_out  = zone_blue[beat.led_index][OUT_W-1:0];
            end
            return res;
        end
        if (beat.pixel_x == LEFT_X) begin
            for (int i = 0; i < LEFT_ZONES; i++) begin
                if (in_window(py, LEFT_LO0 - LEFT_STEP * i)) add_to_zone(LEFT_BASE + i, beat);
            end
        end
        if (beat.pixel_y == TOP_Y) begin
            for (int i = 0; i < HORZ_ZONES; i++) begin
                if (in_window(px, TOP_LO0 + HORZ_STEP * i)) add_to_zone(TOP_BASE + i, beat);
            end
        end
        if (beat.pixel_x == RIGHT_X) begin
            for (int i = 0; i < RIGHT_ZONES; i++) begin
                if (in_window(py, RIGHT_LO0 + RIGHT_STEP * i)) add_to_zone(RIGHT_BASE + i, beat);
            end
        end
        if (beat.pixel_y == BOTTOM_Y) begin
            for (int i = 0; i < HORZ_ZONES; i++) begin
                if (in_window(px, BOTTOM_LO0 - HORZ_STEP * i)) begin
                    add_to_zone(BOTTOM_BASE + i, beat);
                end
            end
        end
        // Frame end: scale every zone after any accumulation of this beat.
        if (beat.pixel_x == FRAME_X && beat.pixel_y == FRAME_Y) begin
            for (int z = 0; z < LED_TOTAL; z++) begin
                zone_red[z]   = zone_red[z] >> FRAME_SHIFT;
                zone_green[z] = zone_green[z] >> FRAME_SHIFT;
                zone_blue[z]  = zone_blue[z] >> FRAME_SHIFT;
            end
            res.frame_done = 1'b1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_out want;
        if (!i_rst_n) begin
            for (int z = 0; z < LED_TOTAL; z++) begin
                zone_red[z]   = '0;
                zone_green[z] = '0;
                zone_blue[z]  = '0;
            end
            outstanding_results.delete();
            mismatches = 0;
        end else begin
            // Push before pop so a same-cycle result would still line up.
            if (i_in_valid && i_in_ready) begin
                outstanding_results.push_back(predict_zone_result(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (outstanding_results.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("[%0t] result beat with nothing outstanding: r=%0d g=%0d b=%0d done=%0b",
                                 $realtime, i_out_data.red_out, i_out_data.green_out,
                                 i_out_data.blue_out, i_out_data.frame_done);
                    end
                    mismatches++;
                end else begin
                    want = outstanding_results.pop_front();
                    if (want.red_out !== i_out_data.red_out ||
                        want.green_out !== i_out_data.green_out ||
                        want.blue_out !== i_out_data.blue_out ||
                        want.frame_done !== i_out_data.frame_done) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("[%0t] mismatch: expected r=%0d g=%0d b=%0d done=%0b, got r=%0d g=%0d b=%0d done=%0b",
                                     $realtime, want.red_out, want.green_out, want.blue_out,
                                     want.frame_done, i_out_data.red_out, i_out_data.green_out,
                                     i_out_data.blue_out, i_out_data.frame_done);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= outstanding_results.size();
    end

endmodule

### tb/tb_screen_edge_zone_color_averager_top.sv
// ----------------------------------------------------------------------------
// tb_screen_edge_zone_color_averager_top
// Drives pixel and read beats into the edge zone averager with random gaps on
// both channels: a directed opening over zone boundaries, off-line pixels,
// out-of-range reads and frame ends, then random traffic with saturating
// bursts into single zones. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_screen_edge_zone_color_averager_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sezca_pkg::*;

    localparam int GAP_MAX     = 11;
    localparam int ITEM_TARGET = 1500;
    localparam int TAIL_CYCLES = 150;
    localparam int HORZ_STEP   = 64;
    localparam int TOP_LO0     = int'(HORZ_LO);
    localparam int BOTTOM_LO0  = int'(HORZ_HI) - ZONE_SPAN + 1;
    localparam int COORD_MAX   = 2047;
    localparam int INDEX_MAX   = 127;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;
    int   fail_count;
    int   pending;

    bit quiet;
    int beats_sent;
    int zone_pixels;
    int reads;
    int frame_ends;
    int bursts;
    int stray_beats;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    screen_edge_zone_color_averager_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    zone_color_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // Lean on the extremes now and then.
    function automatic logic [7:0] draw_level();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in pixel_beat(int x, int y, logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b);
        t_in beat;
        beat.kind      = KIND_PIXEL;
        beat.pixel_x   = x[10:0];
        beat.pixel_y   = y[10:0];
        beat.red_in    = r;
        beat.green_in  = g;
        beat.blue_in   = b;
        beat.led_index = 7'($urandom_range(0, INDEX_MAX));
        return beat;
    endfunction

    function automatic t_in read_beat(int idx);
        t_in beat;
        beat           = pixel_beat($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                    draw_level(), draw_level(), draw_level());
        beat.kind      = KIND_READ;
        beat.led_index = idx[6:0];
        return beat;
    endfunction

    // Place a pixel at the given offset inside a zone's window.
    function automatic t_in zone_pixel(int zone, int offset, logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b);
        if (zone < TOP_BASE) begin
            return pixel_beat(int'(LEFT_X), LEFT_LO0 - LEFT_STEP * (zone - LEFT_BASE) + offset,
                              r, g, b);
        end else if (zone < RIGHT_BASE) begin
            return pixel_beat(TOP_LO0 + HORZ_STEP * (zone - TOP_BASE) + offset, int'(TOP_Y),
                              r, g, b);
        end else if (zone < BOTTOM_BASE) begin
            return pixel_beat(int'(RIGHT_X), RIGHT_LO0 + RIGHT_STEP * (zone - RIGHT_BASE) + offset,
                              r, g, b);
        end
        return pixel_beat(BOTTOM_LO0 - HORZ_STEP * (zone - BOTTOM_BASE) + offset, int'(BOTTOM_Y),
                          r, g, b);
    endfunction

    task automatic send_beat(t_in beat);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!(in_valid && in_ready));
        beats_sent++;
        // Alternate stretches with no idling on either side.
        quiet = (beats_sent % 300) < 60;
    endtask

    task automatic send_random_zone_pixel();
        send_beat(zone_pixel($urandom_range(0, LED_TOTAL - 1), $urandom_range(0, ZONE_SPAN - 1),
                             draw_level(), draw_level(), draw_level()));
        zone_pixels++;
    endtask

    initial begin : result_sink
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial begin : run_limit
        #1_000_000;
        $display("Timeout: run did not drain, %0d results outstanding", pending);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        int         counted;
        int         pick;
        int         zone;
        int         burst_len;
        logic [63:0] raw;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening.
        send_beat(read_beat(0));
        send_beat(read_beat(INDEX_MAX));
        send_beat(zone_pixel(LEFT_BASE, 0, 8'd255, 8'd255, 8'd255));
        send_beat(zone_pixel(TOP_BASE - 1, ZONE_SPAN - 1, 8'd255, 8'd0, 8'd128));
        send_beat(zone_pixel(TOP_BASE, 0, 8'd1, 8'd2, 8'd3));
        send_beat(zone_pixel(RIGHT_BASE - 1, ZONE_SPAN - 1, 8'd0, 8'd255, 8'd0));
        send_beat(zone_pixel(RIGHT_BASE, 0, 8'd255, 8'd255, 8'd255));
        send_beat(zone_pixel(BOTTOM_BASE - 1, ZONE_SPAN - 1, 8'd0, 8'd0, 8'd255));
        send_beat(zone_pixel(BOTTOM_BASE, ZONE_SPAN - 1, 8'd200, 8'd100, 8'd50));
        send_beat(zone_pixel(LED_TOTAL - 1, 0, 8'd255, 8'd255, 8'd255));
        // Off every zone: just past a window, before the first one, far corners.
        send_beat(pixel_beat(int'(LEFT_X), LEFT_LO0 + ZONE_SPAN, 8'd255, 8'd255, 8'd255));
        send_beat(pixel_beat(TOP_LO0 - 1, int'(TOP_Y), 8'd255, 8'd255, 8'd255));
        send_beat(pixel_beat(COORD_MAX, COORD_MAX, 8'd255, 8'd255, 8'd255));
        send_beat(pixel_beat(0, 0, 8'd0, 8'd0, 8'd0));
        send_beat(pixel_beat(int'(LEFT_X), int'(TOP_Y), 8'd255, 8'd255, 8'd255));
        send_beat(read_beat(LED_TOTAL - 1));
        send_beat(read_beat(LED_TOTAL));
        send_beat(read_beat(RIGHT_BASE));
        send_beat(pixel_beat(int'(FRAME_X), int'(FRAME_Y), 8'd255, 8'd255, 8'd255));
        send_beat(read_beat(LEFT_BASE));
        send_beat(read_beat(TOP_BASE - 1));
        send_beat(read_beat(BOTTOM_BASE));
        send_beat(pixel_beat(int'(FRAME_X), int'(FRAME_Y), 8'd0, 8'd0, 8'd0));
        send_beat(read_beat(LEFT_BASE));
        zone_pixels = 8;
        reads       = 9;
        frame_ends  = 2;
        stray_beats = 5;

        counted = 0;
        while (counted < ITEM_TARGET) begin
            pick = $urandom_range(0, 999);
            if (pick < 4) begin
                // Hammer one zone with bright pixels, most times enough to saturate it, then read it.
                zone      = $urandom_range(0, LED_TOTAL - 1);
                burst_len = $urandom_range(66, 100);
                repeat (burst_len) begin
                    send_beat(zone_pixel(zone, $urandom_range(0, ZONE_SPAN - 1),
                                         8'($urandom_range(240, 255)),
                                         8'($urandom_range(240, 255)),
                                         8'($urandom_range(240, 255))));
                end
                send_beat(read_beat(zone));
                zone_pixels += burst_len;
                reads++;
                bursts++;
                counted += burst_len + 1;
            end else if (pick < 11) begin
                send_beat(pixel_beat(int'(FRAME_X), int'(FRAME_Y), draw_level(), draw_level(),
                                     draw_level()));
                frame_ends++;
                counted++;
            end else if (pick < 511) begin
                send_random_zone_pixel();
                counted++;
            end else if (pick < 611) begin
                // On a sample line at any position: mostly gaps and out-of-range spots.
                case ($urandom_range(0, 3))
                    0: send_beat(pixel_beat(int'(LEFT_X), $urandom_range(0, COORD_MAX),
                                            draw_level(), draw_level(), draw_level()));
                    1: send_beat(pixel_beat($urandom_range(0, COORD_MAX), int'(TOP_Y),
                                            draw_level(), draw_level(), draw_level()));
                    2: send_beat(pixel_beat(int'(RIGHT_X), $urandom_range(0, COORD_MAX),
                                            draw_level(), draw_level(), draw_level()));
                    default: send_beat(pixel_beat($urandom_range(0, COORD_MAX), int'(BOTTOM_Y),
                                                  draw_level(), draw_level(), draw_level()));
                endcase
                stray_beats++;
                counted++;
            end else if (pick < 861) begin
                send_beat(read_beat($urandom_range(0, LED_TOTAL - 1)));
                reads++;
                counted++;
            end else if (pick < 911) begin
                send_beat(read_beat($urandom_range(0, INDEX_MAX)));
                reads++;
                counted++;
            end else begin
                raw = {$urandom(), $urandom()};
                send_beat(raw[$bits(t_in)-1:0]);
                stray_beats++;
                counted++;
            end
        end
        in_valid <= 1'b0;

        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Run covered %0d zone pixels, %0d reads, %0d frame ends, %0d saturating bursts",
                 zone_pixels, reads, frame_ends, bursts);
        $display("plus %0d off-zone or random beats; %0d mismatches", stray_beats, fail_count);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
